FILE: hdl/chm_pkg.sv
// Shared types and constants for the chained hash map.
`timescale 1ns / 1ps
package chm_pkg;

    localparam int BUCKETS_DEF      = 8;
    localparam int POOL_ENTRIES_DEF = 64;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key;
        logic [31:0]        value_in;
    } t_req;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [31:0] value_out;
        logic [6:0]  entry_total;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_WALK,
        S_CMP,
        S_ACT,
        S_ALLOC,
        S_REM_FREE
    } t_state;

endpackage

FILE: hdl/chm_bucket_rem.sv
// Bucket index unit: key modulo bucket count, one key byte per cycle when the count is not a power of two.
`timescale 1ns / 1ps
module chm_bucket_rem #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [31:0]                                  i_key,
    output logic                                         o_done,
    output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] o_bucket
);
    import chm_pkg::*;

    localparam int  BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam bit  IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    // reciprocal of the bucket count, scaled so the quotient estimate is at most one low
    localparam int  SH      = BW + 8;
    localparam int  MUL     = (1 << SH) / BUCKETS;

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [2:0]      r_cnt, n_cnt;
    logic [31:0]     r_sh, n_sh;
    logic [BW-1:0]   r_rem, n_rem;
    logic [BW+7:0]   fold;
    logic [BW+16:0]  prod;
    logic [7:0]      quo;
    logic [BW+7:0]   diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sh   = r_sh;
        n_rem  = r_rem;
        fold   = {r_rem, r_sh[31:24]};
        prod   = (BW + 17)'(fold) * (BW + 17)'(MUL);
        quo    = prod[SH+7:SH];
        diff   = fold - (BW + 8)'(quo) * (BW + 8)'(BUCKETS);
        if (diff >= (BW + 8)'(BUCKETS)) begin
            diff = diff - (BW + 8)'(BUCKETS);
        end
        if (i_start) begin
            if (IS_POW2) begin
                n_rem  = i_key[BW-1:0];
                n_done = 1'b1;
            end else begin
                n_sh   = i_key;
                n_rem  = '0;
                n_cnt  = 3'd4;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            // fold in the next key byte and reduce
            n_rem = diff[BW-1:0];
            n_sh  = {r_sh[23:0], 8'd0};
            n_cnt = r_cnt - 3'd1;
            if (r_cnt == 3'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_sh  <= n_sh;
        r_rem <= n_rem;
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem;

endmodule

FILE: hdl/chained_hash_map_int_keys_top.sv
// Top level of the separately chained hash map with integer keys.
//
// One request channel, one result channel. A request (opcode, key, value_in)
// is taken at a rising edge where start is high and busy is low. busy stays
// high until the result is shown; the result is on o_rsp for one cycle,
// marked by o_done, and busy drops in that same cycle, so the next start may
// be taken right at the edge that takes the result. The receiver cannot
// stall the block; every result must be taken in its cycle.
// A request finds its bucket, walks the chain of that bucket and then acts;
// put of a new key adds an allocate step, remove of a hit a free step.
// Each chain entry costs one memory read and one key compare, through the
// single read port of the entry memories. With a bucket count that is not a
// power of two, the bucket index is found bytewise in the remainder unit.
// Opcode 3 returns without a lookup.
// Reset empties every bucket, puts all pool entries on the free list and
// clears the entry count; no sweep is needed, the block is ready at once.
`timescale 1ns / 1ps
module chained_hash_map_int_keys_top #(
    parameter int BUCKETS      = chm_pkg::BUCKETS_DEF,
    parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  chm_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output chm_pkg::t_rsp o_rsp
);
    import chm_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IW = $clog2(POOL_ENTRIES + 1);
    localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);

    t_state        r_state, n_state;
    logic [1:0]    r_op, n_op;
    logic [31:0]   r_key, n_key;
    logic [31:0]   r_val, n_val;
    logic [BW-1:0] r_b, n_b;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_pred, n_pred;
    logic [IW-1:0] r_steps, n_steps;
    logic [IW-1:0] r_hit_link, n_hit_link;
    logic [31:0]   r_vhit, n_vhit;
    logic          r_hit, n_hit;
    logic [IW-1:0] r_free, n_free;
    logic [IW-1:0] r_count, n_count;
    logic [IW-1:0] r_head [BUCKETS];
    logic          head_we;
    logic [IW-1:0] head_wd;
    logic          r_done, n_done;
    t_rsp          r_rsp, n_rsp;

    // entry memories
    logic [31:0]   mem_key  [POOL_ENTRIES];
    logic [31:0]   mem_val  [POOL_ENTRIES];
    logic [IW-1:0] mem_link [POOL_ENTRIES];
    logic [POOL_ENTRIES-1:0] r_lvld;
    logic [AW-1:0] rd_addr;
    logic [31:0]   r_key_rd, r_val_rd;
    logic [IW-1:0] r_link_rd;
    logic          r_lv_rd;
    logic [AW-1:0] r_rd_idx;
    logic [IW-1:0] link_eff;
    logic          kw_en, vw_en, lw_en;
    logic [AW-1:0] kw_addr, vw_addr, lw_addr;
    logic [31:0]   kw_data, vw_data;
    logic [IW-1:0] lw_data;

    logic          hash_start, hash_done;
    logic [BW-1:0] hash_bucket;

    chm_bucket_rem #(
        .BUCKETS (BUCKETS)
    ) u_rem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_key    (i_req.key),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    // a link never written still holds its reset free-list successor
    assign link_eff = r_lv_rd ? r_link_rd : (IW'(r_rd_idx) + IW'(1));

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_val      = r_val;
        n_b        = r_b;
        n_cur      = r_cur;
        n_pred     = r_pred;
        n_steps    = r_steps;
        n_hit_link = r_hit_link;
        n_vhit     = r_vhit;
        n_hit      = r_hit;
        n_free     = r_free;
        n_count    = r_count;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        head_we    = 1'b0;
        head_wd    = NIL;
        hash_start = 1'b0;
        rd_addr    = r_cur[AW-1:0];
        kw_en      = 1'b0;
        kw_addr    = r_free[AW-1:0];
        kw_data    = r_key;
        vw_en      = 1'b0;
        vw_addr    = r_cur[AW-1:0];
        vw_data    = r_val;
        lw_en      = 1'b0;
        lw_addr    = r_pred[AW-1:0];
        lw_data    = r_hit_link;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_req.opcode;
                    n_key = i_req.key;
                    n_val = i_req.value_in;
                    if (i_req.opcode == OP_NONE) begin
                        n_done = 1'b1;
                        n_rsp  = '{status: 1'b0, found: 1'b0, value_out: 32'd0,
                                   entry_total: 7'(r_count)};
                    end else begin
                        hash_start = 1'b1;
                        n_state    = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_b     = hash_bucket;
                    n_cur   = r_head[hash_bucket];
                    n_pred  = NIL;
                    n_steps = '0;
                    n_hit   = 1'b0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                rd_addr = r_cur[AW-1:0];
                if (r_cur >= NIL || r_steps == IW'(POOL_ENTRIES)) begin
                    n_hit   = 1'b0;
                    n_state = S_ACT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_key_rd == r_key) begin
                    n_hit      = 1'b1;
                    n_hit_link = link_eff;
                    n_vhit     = r_val_rd;
                    n_state    = S_ACT;
                end else begin
                    n_pred  = r_cur;
                    n_cur   = link_eff;
                    n_steps = r_steps + IW'(1);
                    n_state = S_WALK;
                end
            end
            S_ACT: begin
                rd_addr = r_free[AW-1:0];
                n_rsp   = '{status: 1'b0, found: r_hit, value_out: 32'd0,
                            entry_total: 7'(r_count)};
                case (r_op)
                    OP_PUT: begin
                        if (r_hit) begin
                            vw_en   = 1'b1;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_free < NIL) begin
                            n_state = S_ALLOC;
                        end else begin
                            n_rsp.status = 1'b1;
                            n_done       = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_GET: begin
                        if (r_hit) begin
                            n_rsp.value_out = r_vhit;
                        end
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: begin
                        if (r_hit) begin
                            // unlink: predecessor or bucket head skips the hit
                            if (r_pred < NIL) begin
                                lw_en = 1'b1;
                            end else begin
                                head_we = 1'b1;
                                head_wd = r_hit_link;
                            end
                            n_state = S_REM_FREE;
                        end else begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_ALLOC: begin
                n_free  = link_eff;
                kw_en   = 1'b1;
                kw_addr = r_free[AW-1:0];
                vw_en   = 1'b1;
                vw_addr = r_free[AW-1:0];
                lw_en   = 1'b1;
                lw_addr = r_free[AW-1:0];
                lw_data = r_head[r_b];
                head_we = 1'b1;
                head_wd = r_free;
                n_count = r_count + IW'(1);
                n_done  = 1'b1;
                n_rsp   = '{status: 1'b0, found: 1'b0, value_out: 32'd0,
                            entry_total: 7'(n_count)};
                n_state = S_IDLE;
            end
            S_REM_FREE: begin
                lw_en   = 1'b1;
                lw_addr = r_cur[AW-1:0];
                lw_data = r_free;
                n_free  = r_cur;
                if (r_count != '0) begin
                    n_count = r_count - IW'(1);
                end
                n_done  = 1'b1;
                n_rsp   = '{status: 1'b0, found: 1'b1, value_out: 32'd0,
                            entry_total: 7'(n_count)};
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
            r_lvld  <= '0;
            for (int i = 0; i < BUCKETS; i++) begin
                r_head[i] <= NIL;
            end
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_count <= n_count;
            r_done  <= n_done;
            if (lw_en) begin
                r_lvld[lw_addr] <= 1'b1;
            end
            if (head_we) begin
                r_head[r_b] <= head_wd;
            end
        end
        r_op       <= n_op;
        r_key      <= n_key;
        r_val      <= n_val;
        r_b        <= n_b;
        r_cur      <= n_cur;
        r_pred     <= n_pred;
        r_steps    <= n_steps;
        r_hit_link <= n_hit_link;
        r_vhit     <= n_vhit;
        r_hit      <= n_hit;
        r_rsp      <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (kw_en) begin
            mem_key[kw_addr] <= kw_data;
        end
        if (vw_en) begin
            mem_val[vw_addr] <= vw_data;
        end
        if (lw_en) begin
            mem_link[lw_addr] <= lw_data;
        end
        r_key_rd  <= mem_key[rd_addr];
        r_val_rd  <= mem_val[rd_addr];
        r_link_rd <= mem_link[rd_addr];
        r_lv_rd   <= r_lvld[rd_addr];
        r_rd_idx  <= rd_addr;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

FILE: hdl/chm_checker.sv
// Port-level checks for the chained hash map, bound to the top level.
`timescale 1ns / 1ps
module chm_checker #(
    parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input chm_pkg::t_rsp o_rsp
);
    import chm_pkg::*;

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while still busy");

    a_start_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("request beat neither started nor answered");

    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status |-> !o_rsp.found && o_rsp.value_out == 32'd0)
        else $error("pool full reported on a hit");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_rsp.entry_total <= 7'(POOL_ENTRIES))
        else $error("entry total beyond pool size");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_rsp.found |-> o_rsp.value_out == 32'd0)
        else $error("value on a miss");

endmodule

bind chained_hash_map_int_keys_top chm_checker #(
    .POOL_ENTRIES (POOL_ENTRIES)
) u_chm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
